FILE: design/tra_pkg.sv
// Shared types and constants for the tree address allocator.
package tra_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ROUTERS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_CHILDREN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_DEPTH    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_ADDRESS  = 3'd4;

  localparam logic [7:0]  RESET_MAX_ROUTERS  = 8'd6;
  localparam logic [7:0]  RESET_MAX_CHILDREN = 8'd20;
  localparam logic [3:0]  RESET_MAX_DEPTH    = 4'd5;
  localparam logic [3:0]  RESET_OWN_DEPTH    = 4'd0;
  localparam logic [15:0] RESET_OWN_ADDRESS  = 16'd0;

  localparam logic        FUNC_START = 1'b0;
  localparam logic        FUNC_ASSOC = 1'b1;

  localparam logic        STATUS_OK      = 1'b0;
  localparam logic        STATUS_REFUSED = 1'b1;

  localparam logic [15:0] NO_SHORT_ADDR = 16'hFFFE;
  localparam logic [15:0] CSKIP_MAX     = 16'hFFFF;
  localparam logic [16:0] POW_LIMIT     = 17'h10000;

  typedef struct packed {
    logic capture;
    logic pow_step;
    logic cskip_fin;
    logic assoc_mul;
    logic assoc_fin;
  } tra_cmd_t;

  typedef struct packed {
    logic pow_done;
  } tra_sts_t;

endpackage

FILE: design/tree_address_allocator.sv
// Start item: one multiply per Cskip power step in ST_POW, then ST_FIN forms Cskip before the result is presented.
// Association item: ST_MUL forms the product, then ST_AFIN adds the address before the result is presented.
// One item at a time; the next item is accepted the cycle after the result is taken.
// A depth at or beyond max skips the power steps and gives a start result with a zero Cskip.
// Reset restores configuration defaults and clears counters and stored Cskip.
module tree_address_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tra_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tra_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // joins_as_router, wants_short_address
  input  logic                           s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata   // status, assigned_address,
                                                        // cskip_value, cskip_saturated
);

  tra_pkg::tra_cmd_t cmd;
  tra_pkg::tra_sts_t sts;
  logic              res_status;
  logic [15:0]       res_addr;
  logic [15:0]       block_size;
  logic              block_clipped;

  tra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_func   (s_axis_tuser),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  tra_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_router     (s_axis_tdata[0]),
    .in_wants      (s_axis_tdata[1]),
    .cmd           (cmd),
    .sts           (sts),
    .res_status    (res_status),
    .res_addr      (res_addr),
    .block_size    (block_size),
    .block_clipped (block_clipped)
  );

  assign m_axis_tdata = {6'd0, block_clipped, block_size, res_addr, res_status};

endmodule

FILE: design/tra_ctrl.sv
// Controller state machine sequencing Cskip computation and address assignment.
module tra_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_func,
  input  logic            out_ready,
  input  tra_pkg::tra_sts_t sts,
  output tra_pkg::tra_cmd_t cmd,
  output logic            in_ready,
  output logic            out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_FIN,
    ST_MUL,
    ST_AFIN,
    ST_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            if (in_func == tra_pkg::FUNC_START) begin
              state <= ST_POW;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_POW: begin
          if (sts.pow_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state     <= ST_OUT;
          out_valid <= 1'b1;
        end
        ST_MUL: begin
          state <= ST_AFIN;
        end
        ST_AFIN: begin
          state     <= ST_OUT;
          out_valid <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == ST_IDLE) && in_valid && in_ready;
    cmd.pow_step  = (state == ST_POW) && !sts.pow_done;
    cmd.cskip_fin = (state == ST_FIN);
    cmd.assoc_mul = (state == ST_MUL);
    cmd.assoc_fin = (state == ST_AFIN);
  end

endmodule

FILE: design/tra_dp.sv
// Datapath holding configuration, counters, Cskip and the result register.
module tra_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tra_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_router,
  input  logic                              in_wants,
  input  tra_pkg::tra_cmd_t                 cmd,
  output tra_pkg::tra_sts_t                 sts,
  output logic                              res_status,
  output logic [15:0]                       res_addr,
  output logic [15:0]                       block_size,
  output logic                              block_clipped
);

  logic [7:0]  max_routers;
  logic [7:0]  max_children;
  logic [3:0]  max_depth;
  logic [3:0]  own_depth;
  logic [15:0] own_address;

  logic [7:0]  router_count;
  logic [7:0]  end_device_count;

  logic        router;
  logic        wants;
  logic        depth_over;
  logic [3:0]  pow_cnt;
  logic [16:0] pow_sum;
  logic [15:0] product;

  logic [25:0] pow_sum_next;
  logic [25:0] cskip_full;
  logic [23:0] product_next;
  logic [8:0]  child_total;
  logic        refuse;
  logic [15:0] addr_next;

  assign sts.pow_done = (pow_cnt == 4'd0);

  assign pow_sum_next = 26'(pow_sum) * 26'(max_routers) + 26'd1;
  assign cskip_full   = 26'(pow_sum) * 26'(max_children) + 26'd1;
  assign product_next = block_size * (router ? router_count : max_routers);
  assign child_total  = {1'b0, router_count} + {1'b0, end_device_count};
  assign refuse       = (child_total >= {1'b0, max_children}) ||
                        (router && (router_count >= max_routers));

  always_comb begin
    if (!wants) begin
      addr_next = tra_pkg::NO_SHORT_ADDR;
    end else if (router) begin
      addr_next = own_address + product + 16'd1;
    end else begin
      addr_next = own_address + product + {8'd0, end_device_count} + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_routers  <= tra_pkg::RESET_MAX_ROUTERS;
      max_children <= tra_pkg::RESET_MAX_CHILDREN;
      max_depth    <= tra_pkg::RESET_MAX_DEPTH;
      own_depth    <= tra_pkg::RESET_OWN_DEPTH;
      own_address  <= tra_pkg::RESET_OWN_ADDRESS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tra_pkg::REG_MAX_ROUTERS:  max_routers  <= cfg_data[7:0];
        tra_pkg::REG_MAX_CHILDREN: max_children <= cfg_data[7:0];
        tra_pkg::REG_MAX_DEPTH:    max_depth    <= cfg_data[3:0];
        tra_pkg::REG_OWN_DEPTH:    own_depth    <= cfg_data[3:0];
        tra_pkg::REG_OWN_ADDRESS:  own_address  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      router_count     <= '0;
      end_device_count <= '0;
      block_size       <= '0;
      block_clipped    <= 1'b0;
      pow_cnt          <= '0;
    end else begin
      if (cmd.capture) begin
        if (own_depth >= max_depth) begin
          pow_cnt <= '0;
        end else begin
          pow_cnt <= max_depth - own_depth - 4'd1;
        end
      end else if (cmd.pow_step) begin
        pow_cnt <= pow_cnt - 4'd1;
      end
      if (cmd.cskip_fin) begin
        if (depth_over) begin
          block_size    <= '0;
          block_clipped <= 1'b0;
        end else if (cskip_full > 26'(tra_pkg::CSKIP_MAX)) begin
          block_size    <= tra_pkg::CSKIP_MAX;
          block_clipped <= 1'b1;
        end else begin
          block_size    <= cskip_full[15:0];
          block_clipped <= 1'b0;
        end
      end
      if (cmd.assoc_fin && !refuse) begin
        if (router) begin
          router_count <= router_count + 8'd1;
        end else begin
          end_device_count <= end_device_count + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      router     <= in_router;
      wants      <= in_wants;
      depth_over <= (own_depth >= max_depth);
      pow_sum    <= '0;
    end else if (cmd.pow_step) begin
      if (pow_sum_next > 26'(tra_pkg::POW_LIMIT)) begin
        pow_sum <= tra_pkg::POW_LIMIT;
      end else begin
        pow_sum <= pow_sum_next[16:0];
      end
    end
    if (cmd.assoc_mul) begin
      product <= product_next[15:0];
    end
    if (cmd.cskip_fin) begin
      res_status <= tra_pkg::STATUS_OK;
      res_addr   <= '0;
    end else if (cmd.assoc_fin) begin
      if (refuse) begin
        res_status <= tra_pkg::STATUS_REFUSED;
        res_addr   <= tra_pkg::NO_SHORT_ADDR;
      end else begin
        res_status <= tra_pkg::STATUS_OK;
        res_addr   <= addr_next;
      end
    end
  end

endmodule
